// File: design/accr_pkg.sv
// shared types, register map, and lookup tables for the audio codec control registers
// no dependencies

package accr_pkg;

  typedef enum logic [1:0] {
    OP_WR_START = 2'd0,
    OP_DATA     = 2'd1,
    OP_STOP     = 2'd2,
    OP_EXT_CLK  = 2'd3
  } accr_op_e;

  localparam logic [6:0] REG_LINVOL  = 7'h00;
  localparam logic [6:0] REG_RINVOL  = 7'h01;
  localparam logic [6:0] REG_LOUT1   = 7'h02;
  localparam logic [6:0] REG_ROUT1   = 7'h03;
  localparam logic [6:0] REG_ADCDAC  = 7'h05;
  localparam logic [6:0] REG_IFACE   = 7'h07;
  localparam logic [6:0] REG_SRATE   = 7'h08;
  localparam logic [6:0] REG_RESET   = 7'h0f;
  localparam logic [6:0] REG_PWR     = 7'h19;
  localparam logic [6:0] REG_LOUT2   = 7'h28;
  localparam logic [6:0] REG_ROUT2   = 7'h29;
  localparam logic [6:0] REG_MONOOUT = 7'h2a;

  localparam logic [5:0] IN_VOL_RST  = 6'h17;
  localparam logic [6:0] OUT_VOL_RST = 7'h79;
  localparam logic [6:0] OUT_VOL_MAX = 7'h7f;
  localparam logic [1:0] CNT_FULL    = 2'd2;
  localparam int unsigned NumOutVol  = 5;

  typedef struct packed {
    accr_op_e    opcode;
    logic [7:0]  data_byte;
    logic [17:0] ext_clock_hz;
  } accr_in_t;

  typedef struct packed {
    logic        nack;
    logic        enable;
    logic        dac_mute;
    logic [17:0] adc_rate_hz;
    logic [17:0] dac_rate_hz;
    logic [7:0]  in_gain_left;
    logic [7:0]  in_gain_right;
    logic [7:0]  speaker_gain_left;
    logic [7:0]  speaker_gain_right;
    logic [7:0]  phones_gain_left;
    logic [7:0]  phones_gain_right;
    logic [7:0]  mono_gain;
  } accr_out_t;

  // out_vol order: lout1, rout1, lout2, rout2, mono
  typedef struct packed {
    logic                              power_on;
    logic                              mute_flag;
    logic                              master_mode;
    logic [4:0]                        rate_index;
    logic [17:0]                       external_hz;
    logic [1:0][5:0]                   in_vol;
    logic [1:0]                        in_mute;
    logic [NumOutVol-1:0][6:0]         out_vol;
  } accr_state_t;

  function automatic logic [17:0] adc_rate(input logic [4:0] idx);
    logic [17:0] r;
    case (idx)
      5'd0, 5'd1, 5'd2, 5'd3:     r = 18'd48000;
      5'd4, 5'd5, 5'd6, 5'd7:     r = 18'd8000;
      5'd8, 5'd9:                 r = 18'd12000;
      5'd10, 5'd11:               r = 18'd16000;
      5'd12, 5'd13:               r = 18'd32000;
      5'd14, 5'd15:               r = 18'd96000;
      5'd16, 5'd17, 5'd18, 5'd19: r = 18'd44100;
      5'd20, 5'd21, 5'd22, 5'd23: r = 18'd8018;
      5'd24, 5'd25:               r = 18'd11025;
      5'd26, 5'd27:               r = 18'd22050;
      5'd28, 5'd29:               r = 18'd24000;
      default:                    r = 18'd88200;
    endcase
    return r;
  endfunction

  function automatic logic [17:0] dac_rate(input logic [4:0] idx);
    logic [17:0] r;
    case (idx)
      5'd0, 5'd1, 5'd4, 5'd5:     r = 18'd48000;
      5'd2, 5'd3, 5'd6, 5'd7:     r = 18'd8000;
      5'd8, 5'd9:                 r = 18'd12000;
      5'd10, 5'd11:               r = 18'd16000;
      5'd12, 5'd13:               r = 18'd32000;
      5'd14, 5'd15:               r = 18'd96000;
      5'd16, 5'd17, 5'd20, 5'd21: r = 18'd44100;
      5'd18, 5'd19, 5'd22, 5'd23: r = 18'd8018;
      5'd24, 5'd25:               r = 18'd11025;
      5'd26, 5'd27:               r = 18'd22050;
      5'd28, 5'd29:               r = 18'd24000;
      default:                    r = 18'd88200;
    endcase
    return r;
  endfunction

  // attenuation step is (0x7f - code) / 3, divide by 3 as multiply by 171 then shift by 9
  function automatic logic [7:0] db_gain(input logic [6:0] code);
    logic [6:0]  atten;
    logic [14:0] prod;
    logic [5:0]  idx;
    logic [7:0]  g;
    atten = OUT_VOL_MAX - code;
    prod  = 15'(atten) * 15'd171;
    idx   = prod[14:9];
    case (idx)
      6'd0:  g = 8'd255;
      6'd1:  g = 8'd227;
      6'd2:  g = 8'd203;
      6'd3:  g = 8'd181;
      6'd4:  g = 8'd161;
      6'd5:  g = 8'd143;
      6'd6:  g = 8'd128;
      6'd7:  g = 8'd114;
      6'd8:  g = 8'd102;
      6'd9:  g = 8'd90;
      6'd10: g = 8'd81;
      6'd11: g = 8'd72;
      6'd12: g = 8'd64;
      6'd13: g = 8'd57;
      6'd14: g = 8'd51;
      6'd15: g = 8'd45;
      6'd16: g = 8'd40;
      6'd17: g = 8'd36;
      6'd18: g = 8'd32;
      6'd19: g = 8'd29;
      6'd20: g = 8'd26;
      6'd21: g = 8'd23;
      6'd22: g = 8'd20;
      6'd23: g = 8'd18;
      6'd24: g = 8'd16;
      6'd25: g = 8'd14;
      6'd26: g = 8'd13;
      6'd27: g = 8'd11;
      6'd28: g = 8'd10;
      6'd29: g = 8'd9;
      6'd30: g = 8'd8;
      6'd31: g = 8'd7;
      6'd32, 6'd33: g = 8'd6;
      6'd34, 6'd35: g = 8'd5;
      6'd36, 6'd37: g = 8'd4;
      6'd38, 6'd39, 6'd40: g = 8'd3;
      default: g = 8'd2;
    endcase
    return g;
  endfunction

endpackage

// File: design/audio_codec_control_registers_unit.sv
// top level of the audio codec control port: state update, gain and rate lookup, result register
// depends on accr_pkg and accr_state
//
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_ready_o   | in_data_i  (accr_in_t)
// out     | output    | out_valid_o / out_ready_i | out_data_o (accr_out_t)
//
// one transaction per cycle unless the output stalls; each input transaction yields one result
// in the next cycle, set by the single result register after the decode and table lookup
// in_ready_o is high while the result register is empty or being taken in the same cycle
// reset restores the register defaults at once; no clearing pass

module audio_codec_control_registers_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  accr_pkg::accr_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output accr_pkg::accr_out_t out_data_o
);

  logic                  accept;
  logic                  nack;
  logic                  use_tab;
  logic                  out_valid_q;
  accr_pkg::accr_state_t st_d;
  accr_pkg::accr_out_t   res_d, res_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  accr_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_i      (in_data_i),
    .state_d_o (st_d),
    .nack_o    (nack)
  );

  assign use_tab = st_d.master_mode || (st_d.external_hz == 18'd0);

  always_comb begin
    res_d.nack               = nack;
    res_d.enable             = st_d.power_on;
    res_d.dac_mute           = st_d.mute_flag;
    res_d.adc_rate_hz        = use_tab ? accr_pkg::adc_rate(st_d.rate_index) : st_d.external_hz;
    res_d.dac_rate_hz        = use_tab ? accr_pkg::dac_rate(st_d.rate_index) : st_d.external_hz;
    res_d.in_gain_left       = st_d.in_mute[0] ? 8'd0 : {st_d.in_vol[0], 2'b00};
    res_d.in_gain_right      = st_d.in_mute[1] ? 8'd0 : {st_d.in_vol[1], 2'b00};
    res_d.speaker_gain_left  = accr_pkg::db_gain(st_d.out_vol[2]);
    res_d.speaker_gain_right = accr_pkg::db_gain(st_d.out_vol[3]);
    res_d.phones_gain_left   = accr_pkg::db_gain(st_d.out_vol[0]);
    res_d.phones_gain_right  = accr_pkg::db_gain(st_d.out_vol[1]);
    res_d.mono_gain          = accr_pkg::db_gain(st_d.out_vol[4]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

// File: design/accr_state.sv
// register file and two-byte write decoder of the codec control port
// depends on accr_pkg

module accr_state (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  accr_pkg::accr_in_t   in_i,
  output accr_pkg::accr_state_t state_d_o,
  output logic                 nack_o
);

  accr_pkg::accr_state_t st_q, st_d;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] first_q, first_d;
  logic [8:0] value;
  logic [6:0] addr;

  assign addr  = first_q[7:1];
  assign value = {first_q[0], in_i.data_byte};

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    nack_o  = 1'b0;
    case (in_i.opcode)
      accr_pkg::OP_WR_START: begin
        cnt_d = 2'd0;
      end
      accr_pkg::OP_DATA: begin
        if (cnt_q >= accr_pkg::CNT_FULL) begin
          nack_o = 1'b1;
        end else if (cnt_q == 2'd0) begin
          first_d = in_i.data_byte;
          cnt_d   = 2'd1;
        end else begin
          cnt_d = accr_pkg::CNT_FULL;
          case (addr)
            accr_pkg::REG_LINVOL: begin
              st_d.in_vol[0]  = value[5:0];
              st_d.in_mute[0] = value[7];
            end
            accr_pkg::REG_RINVOL: begin
              st_d.in_vol[1]  = value[5:0];
              st_d.in_mute[1] = value[7];
            end
            accr_pkg::REG_LOUT1:   st_d.out_vol[0] = value[6:0];
            accr_pkg::REG_ROUT1:   st_d.out_vol[1] = value[6:0];
            accr_pkg::REG_LOUT2:   st_d.out_vol[2] = value[6:0];
            accr_pkg::REG_ROUT2:   st_d.out_vol[3] = value[6:0];
            accr_pkg::REG_MONOOUT: st_d.out_vol[4] = value[6:0];
            accr_pkg::REG_ADCDAC:  st_d.mute_flag   = value[3];
            accr_pkg::REG_IFACE:   st_d.master_mode = value[6];
            accr_pkg::REG_SRATE:   st_d.rate_index  = value[5:1];
            accr_pkg::REG_PWR:     st_d.power_on    = (value[8:6] == 3'd3);
            accr_pkg::REG_RESET: begin
              st_d.power_on   = 1'b0;
              st_d.mute_flag  = 1'b1;
              st_d.rate_index = '0;
              st_d.in_vol     = {2{accr_pkg::IN_VOL_RST}};
              st_d.in_mute    = '0;
              st_d.out_vol    = {accr_pkg::NumOutVol{accr_pkg::OUT_VOL_RST}};
              cnt_d           = 2'd0;
            end
            default: ;
          endcase
        end
      end
      accr_pkg::OP_EXT_CLK: begin
        st_d.external_hz = in_i.ext_clock_hz;
      end
      default: ;
    endcase
  end

  assign state_d_o = st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.power_on    <= 1'b0;
      st_q.mute_flag   <= 1'b1;
      st_q.master_mode <= 1'b0;
      st_q.rate_index  <= '0;
      st_q.external_hz <= '0;
      st_q.in_vol      <= {2{accr_pkg::IN_VOL_RST}};
      st_q.in_mute     <= '0;
      st_q.out_vol     <= {accr_pkg::NumOutVol{accr_pkg::OUT_VOL_RST}};
      cnt_q            <= 2'd0;
      first_q          <= 8'd0;
    end else if (accept_i) begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
    end
  end

endmodule
